>>> hdl/i2cbs_pkg.sv
// Package for the I2C master bit sequencer: operation codes, beat payload
// types and the sequencer state record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

  // Bits shifted per data byte
  localparam int unsigned BitsPerByte = 8;

  // Phase counts derived from the byte length
  localparam int unsigned PhaseW       = 5;
  localparam int unsigned WriteBitEnd  = 3 * BitsPerByte;      // last data phase of a write
  localparam int unsigned WriteAckHigh = WriteBitEnd + 1;      // SCL high for ack slot
  localparam int unsigned WriteAckLow  = WriteBitEnd + 2;      // sample ack, SCL low
  localparam int unsigned ReadEnd      = 2 * BitsPerByte;      // phase of eighth sample

  // Operation codes; OP_TICK doubles as the idle marker of the active command
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_e;

  // Input beat
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } out_item_t;

  // Sequencer state
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [1:0]        wsub;       // position within a three-phase write bit
    logic [7:0]        shift;
    op_e               cmd;
    logic              scl;
    logic              sda;
    logic              ack;
    logic [7:0]        last_read;
  } state_t;

endpackage

`default_nettype wire

>>> hdl/i2cbs_step.sv
// Next-state logic of the I2C master bit sequencer: one beat in, one update.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_step (
  input  i2cbs_pkg::state_t   cur_i,
  input  i2cbs_pkg::in_item_t item_i,
  output i2cbs_pkg::state_t   nxt_o,
  output logic                done_o
);
  import i2cbs_pkg::*;

  logic [PhaseW-1:0] ph_n;
  logic [7:0]        shift_in;

  assign ph_n     = cur_i.phase + PhaseW'(1);
  assign shift_in = {cur_i.shift[6:0], item_i.sda_in};

  // Apply a command or advance one phase
  always_comb begin
    nxt_o  = cur_i;
    done_o = 1'b0;
    case (item_i.op)
      OP_TICK: begin
        if (cur_i.cmd != OP_TICK) begin
          nxt_o.phase = ph_n;
          case (cur_i.cmd)
            OP_START: begin
              if (ph_n == PhaseW'(1)) begin
                nxt_o.sda = 1'b0;
              end else begin
                nxt_o.scl = 1'b0;
                done_o    = 1'b1;
              end
            end
            OP_STOP: begin
              if (ph_n == PhaseW'(1)) begin
                nxt_o.sda = 1'b1;
              end else begin
                done_o = 1'b1;
              end
            end
            OP_ACK, OP_NACK: begin
              if (ph_n == PhaseW'(1)) begin
                nxt_o.scl = 1'b1;
              end else if (ph_n == PhaseW'(2)) begin
                nxt_o.scl = 1'b0;
              end else begin
                done_o = 1'b1;
              end
            end
            OP_WRITE: begin
              if (ph_n <= PhaseW'(WriteBitEnd)) begin
                nxt_o.wsub = (cur_i.wsub == 2'd2) ? 2'd0 : cur_i.wsub + 2'd1;
                case (cur_i.wsub)
                  2'd0: nxt_o.scl = 1'b1;
                  2'd1: nxt_o.scl = 1'b0;
                  default: begin
                    if (ph_n == PhaseW'(WriteBitEnd)) begin
                      // release SDA for the ack slot
                      nxt_o.sda = 1'b1;
                    end else begin
                      nxt_o.shift = {cur_i.shift[6:0], 1'b0};
                      nxt_o.sda   = cur_i.shift[6];
                    end
                  end
                endcase
              end else if (ph_n == PhaseW'(WriteAckHigh)) begin
                nxt_o.scl = 1'b1;
              end else if (ph_n == PhaseW'(WriteAckLow)) begin
                nxt_o.ack = item_i.sda_in;
                nxt_o.scl = 1'b0;
              end else begin
                done_o = 1'b1;
              end
            end
            OP_READ: begin
              if (ph_n[0]) begin
                nxt_o.scl = 1'b1;
              end else begin
                nxt_o.shift = shift_in;
                nxt_o.scl   = 1'b0;
                if (ph_n >= PhaseW'(ReadEnd)) begin
                  nxt_o.last_read = shift_in;
                  done_o          = 1'b1;
                end
              end
            end
            default: ;
          endcase
          // Drop back to idle at the end of a sequence
          if (done_o) begin
            nxt_o.cmd   = OP_TICK;
            nxt_o.phase = '0;
          end
        end
      end
      OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK, OP_NACK: begin
        if (cur_i.cmd == OP_TICK) begin
          nxt_o.phase = '0;
          nxt_o.cmd   = op_e'(item_i.op);
          case (item_i.op)
            OP_START: begin
              nxt_o.sda = 1'b1;
              nxt_o.scl = 1'b1;
            end
            OP_STOP: begin
              nxt_o.sda = 1'b0;
              nxt_o.scl = 1'b1;
            end
            OP_ACK:  nxt_o.sda = 1'b0;
            OP_NACK: nxt_o.sda = 1'b1;
            OP_WRITE: begin
              nxt_o.shift = item_i.data_byte;
              nxt_o.sda   = item_i.data_byte[7];
              nxt_o.wsub  = 2'd0;
            end
            OP_READ: begin
              nxt_o.shift = '0;
              nxt_o.sda   = 1'b1;
              nxt_o.scl   = 1'b0;
            end
            default: nxt_o.cmd = OP_TICK;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer, top level: state register, step logic and
// result register. Depends on i2cbs_pkg and i2cbs_step.
// The result beat of an accepted input beat is registered and valid in the next cycle.
// Throughput: one beat per cycle while the result side takes results; the state update is a single step of
// i2cbs_step and the result register frees as soon as it is taken.
// Reset: asynchronous; idle, SCL and SDA released high, flags and read byte
// cleared, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cbs_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cbs_pkg::out_item_t  out_data_o
);
  import i2cbs_pkg::*;

  state_t    state_q, state_d;
  out_item_t out_q;
  logic      out_valid_q;
  logic      done;
  logic      in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  i2cbs_step u_step (
    .cur_i  (state_q),
    .item_i (in_data_i),
    .nxt_o  (state_d),
    .done_o (done)
  );

  // Hold sequencer state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= '0;
      state_q.wsub      <= '0;
      state_q.shift     <= '0;
      state_q.cmd       <= OP_TICK;
      state_q.scl       <= 1'b1;
      state_q.sda       <= 1'b1;
      state_q.ack       <= 1'b0;
      state_q.last_read <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.scl       <= state_d.scl;
      out_q.sda_out   <= state_d.sda;
      out_q.busy_res  <= (state_d.cmd != OP_TICK);
      out_q.done_res  <= done;
      out_q.read_data <= state_d.last_read;
      out_q.no_ack    <= state_d.ack;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Idle state always sits at phase zero
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cmd == OP_TICK |-> state_q.phase == '0)
    else $error("idle with nonzero phase");

  // Phase never runs past the end of a write sequence
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PhaseW'(WriteAckLow))
    else $error("phase out of range");

  // Write bit position stays within three phases
  a_wsub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.wsub != 2'd3)
    else $error("write sub-phase out of range");

  // A finished sequence reports not busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done while busy");

  // A tick while idle leaves the state untouched
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == OP_TICK && state_q.cmd == OP_TICK |=> $stable(state_q))
    else $error("idle tick changed state");

endmodule

`default_nettype wire

>>> sim/i2cbs_line_checker.sv
// Line checker for the I2C master bit sequencer: predicts each result beat from
// the accepted input beats and compares it field by field with the block output.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_line_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  i2cbs_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  i2cbs_pkg::out_item_t out_data_i,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   done_cnt_o
);
  import i2cbs_pkg::*;

  // Predicted sequencer state
  logic [4:0] ph_q;
  logic [7:0] shift_q;
  op_e        cmd_q;
  logic       scl_q;
  logic       sda_q;
  logic       ack_q;
  logic [7:0] rd_byte_q;

  out_item_t  line_results_q[$];
  int         fails;
  int         dones;

  // Apply one input beat to the predicted state and return the line levels
  function automatic out_item_t predict_lines(in_item_t it);
    out_item_t r;
    logic      fin;
    int        sub;
    fin = 1'b0;
    if (it.op == OP_TICK) begin
      if (cmd_q != OP_TICK) begin
        ph_q = ph_q + 5'd1;
        case (cmd_q)
          OP_START: begin
            if (ph_q == 5'd1) sda_q = 1'b0;
            else begin
              scl_q = 1'b0;
              fin = 1'b1;
            end
          end
          OP_STOP: begin
            if (ph_q == 5'd1) sda_q = 1'b1;
            else fin = 1'b1;
          end
          OP_ACK, OP_NACK: begin
            if (ph_q == 5'd1) scl_q = 1'b1;
            else if (ph_q == 5'd2) scl_q = 1'b0;
            else fin = 1'b1;
          end
          OP_WRITE: begin
            if (ph_q <= WriteBitEnd) begin
              // Three phases per bit: SCL high, SCL low, next bit on SDA
              sub = (int'(ph_q) - 1) % 3;
              if (sub == 0) scl_q = 1'b1;
              else if (sub == 1) scl_q = 1'b0;
              else if (ph_q == WriteBitEnd) sda_q = 1'b1;
              else begin
                shift_q = {shift_q[6:0], 1'b0};
                sda_q = shift_q[7];
              end
            end else if (ph_q == WriteAckHigh) begin
              scl_q = 1'b1;
            end else if (ph_q == WriteAckLow) begin
              ack_q = it.sda_in;
              scl_q = 1'b0;
            end else begin
              fin = 1'b1;
            end
          end
          OP_READ: begin
            if (ph_q[0]) scl_q = 1'b1;
            else begin
              // Sample on the tick that ends SCL high
              shift_q = {shift_q[6:0], it.sda_in};
              scl_q = 1'b0;
              if (ph_q >= ReadEnd) begin
                rd_byte_q = shift_q;
                fin = 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (fin) begin
          cmd_q = OP_TICK;
          ph_q = '0;
        end
      end
    end else if (it.op <= OP_NACK && cmd_q == OP_TICK) begin
      // Accept a command only when idle; reserved op code falls through
      ph_q = '0;
      cmd_q = op_e'(it.op);
      case (cmd_q)
        OP_START: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
        end
        OP_STOP: begin
          sda_q = 1'b0;
          scl_q = 1'b1;
        end
        OP_ACK:  sda_q = 1'b0;
        OP_NACK: sda_q = 1'b1;
        OP_WRITE: begin
          shift_q = it.data_byte;
          sda_q = it.data_byte[7];
        end
        OP_READ: begin
          shift_q = '0;
          sda_q = 1'b1;
          scl_q = 1'b0;
        end
        default: ;
      endcase
    end
    r.scl       = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (cmd_q != OP_TICK);
    r.done_res  = fin;
    r.read_data = rd_byte_q;
    r.no_ack    = ack_q;
    return r;
  endfunction

  function automatic int check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Retire result beats first, then queue the prediction for a new input beat
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      ph_q = '0;
      shift_q = '0;
      cmd_q = OP_TICK;
      scl_q = 1'b1;
      sda_q = 1'b1;
      ack_q = 1'b0;
      rd_byte_q = '0;
      line_results_q.delete();
      fails = 0;
      dones = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
      done_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (line_results_q.size() == 0) begin
          $error("result beat with no expected result pending");
          fails++;
        end else begin
          want = line_results_q.pop_front();
          fails += check_field("scl", 8'(want.scl), 8'(out_data_i.scl));
          fails += check_field("sda_out", 8'(want.sda_out), 8'(out_data_i.sda_out));
          fails += check_field("busy_res", 8'(want.busy_res), 8'(out_data_i.busy_res));
          fails += check_field("done_res", 8'(want.done_res), 8'(out_data_i.done_res));
          fails += check_field("read_data", want.read_data, out_data_i.read_data);
          fails += check_field("no_ack", 8'(want.no_ack), 8'(out_data_i.no_ack));
          if (want.done_res) dones++;
        end
      end
      if (in_valid_i && in_ready_i) line_results_q.push_back(predict_lines(in_data_i));
      fail_cnt_o <= fails;
      pending_o <= line_results_q.size();
      done_cnt_o <= dones;
    end
  end

endmodule

>>> sim/tb.sv
// Testbench top for i2c_master_bit_sequencer_core: clock, reset, command and
// tick stimulus, result-side stalls and the verdict. Depends on i2cbs_pkg and
// i2cbs_line_checker.
`timescale 1ns / 1ps

module tb;
  import i2cbs_pkg::*;

  localparam int NumItems  = 1250;
  localparam int QuietFrom = 1100;
  localparam int IdleLimit = 2000;
  localparam int LongHold  = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_cnt;
  int pending;
  int done_cnt;
  int beats_sent = 0;
  int idle_cycles = 0;
  int cmd_seen[8];
  bit quiet = 1'b0;
  bit sender_gaps = 1'b0;
  bit hold_req = 1'b0;

  i2c_master_bit_sequencer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  i2cbs_line_checker u_line_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .done_cnt_o  (done_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ticks needed to carry a command from acceptance to its done pulse
  function automatic int tick_count(op_e op);
    case (op)
      OP_START, OP_STOP: return 2;
      OP_ACK, OP_NACK:   return 3;
      OP_WRITE:          return WriteAckLow + 1;
      OP_READ:           return ReadEnd;
      default:           return 0;
    endcase
  endfunction

  // Offer one input beat and hold it until accepted; maybe idle afterwards
  task automatic send_beat(logic [2:0] op, logic [7:0] data, logic sda);
    in_item_t it;
    it.op = op;
    it.data_byte = data;
    it.sda_in = sda;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    beats_sent++;
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Issue a command and its ticks; sda_mode 0/1 holds SDA, 2 randomizes it
  task automatic run_cmd(op_e op, logic [7:0] data, int sda_mode, int ticks, bit noise);
    send_beat(op, data, 1'($urandom_range(0, 1)));
    cmd_seen[op]++;
    for (int i = 0; i < ticks; i++) begin
      if (noise && $urandom_range(0, 11) == 0) begin
        // Command or reserved op while busy: must be ignored
        send_beat(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
      send_beat(OP_TICK, 8'($urandom_range(0, 255)),
                (sda_mode < 2) ? sda_mode[0] : 1'($urandom_range(0, 1)));
    end
  endtask

  // Stimulus and verdict
  initial begin
    op_e op;
    int  ticks;
    int  roll;
    int  n_cmd;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reserved op, idle tick, command while busy, field extremes
    send_beat(3'd7, 8'hFF, 1'b1);
    send_beat(OP_TICK, 8'h00, 1'b1);
    send_beat(OP_START, 8'h00, 1'b0);
    send_beat(OP_WRITE, 8'hFF, 1'b1);
    send_beat(OP_TICK, 8'hFF, 1'b0);
    send_beat(OP_TICK, 8'h00, 1'b1);
    cmd_seen[OP_START]++;
    run_cmd(OP_WRITE, 8'hFF, 0, tick_count(OP_WRITE), 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1, tick_count(OP_WRITE), 1'b0);
    run_cmd(OP_READ, 8'hFF, 1, tick_count(OP_READ), 1'b0);
    run_cmd(OP_READ, 8'h00, 0, tick_count(OP_READ), 1'b0);
    run_cmd(OP_ACK, 8'h5A, 2, tick_count(OP_ACK), 1'b0);
    run_cmd(OP_NACK, 8'hA5, 2, tick_count(OP_NACK), 1'b0);
    run_cmd(OP_STOP, 8'h81, 2, tick_count(OP_STOP), 1'b0);

    // Random: mostly complete sequences, some noise and cut-short ones
    n_cmd = 0;
    while (beats_sent < NumItems) begin
      quiet = (beats_sent >= QuietFrom);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (n_cmd == 15) hold_req = 1'b1;
      if (n_cmd == 30) begin
        // Pause the sender until every expected result has come back
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        send_beat(3'd7, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (roll == 1) begin
        send_beat(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        op = op_e'($urandom_range(1, 6));
        ticks = tick_count(op);
        if (roll == 2) ticks = $urandom_range(0, ticks - 1);
        run_cmd(op, 8'($urandom_range(0, 255)), 2, ticks, 1'b1);
      end
      n_cmd++;
    end

    // Drain, then let the block settle
    quiet = 1'b1;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d beats; commands offered: start %0d, stop %0d, write %0d, read %0d,",
             beats_sent, cmd_seen[OP_START], cmd_seen[OP_STOP], cmd_seen[OP_WRITE],
             cmd_seen[OP_READ]);
    $display("ack %0d, nack %0d; %0d done pulses, with a %0d-cycle result hold-off and a drain.",
             cmd_seen[OP_ACK], cmd_seen[OP_NACK], done_cnt, LongHold);
    if (fail_cnt == 0 && pending == 0) begin
      $display("i2c_master_bit_sequencer_core test passed");
    end else begin
      $display("i2c_master_bit_sequencer_core test failed");
    end
    $finish;
  end

  // Result side: random stall bursts, calm stretches and one long hold-off
  initial begin
    bit stall_mode;
    stall_mode = 1'b1;
    out_ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (stall_mode && !quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("i2c_master_bit_sequencer_core test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
